FILE: rtl/plain_substring_search_top_assert.svh
// Assertion macros used by the substring search top level.
`ifndef PLAIN_SUBSTRING_SEARCH_TOP_ASSERT_SVH
`define PLAIN_SUBSTRING_SEARCH_TOP_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, held off during reset.
`define PSS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, held off during reset.
`define PSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PSS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define PSS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/pss_pkg.sv
// Types and constants for the substring search block.
package pss_pkg;

  localparam int CHAR_W  = 21;
  localparam int CFG_W   = 16;
  localparam int POS_W   = 17;
  localparam int LEN_W   = 6;
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 2;
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 24;

  typedef enum logic [KIND_W-1:0] {
    KIND_START   = 2'd0,
    KIND_PATTERN = 2'd1,
    KIND_TEXT    = 2'd2
  } pss_kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_PAT_LONG  = 2'd2,
    ST_TEXT_LONG = 2'd3
  } pss_status_t;

  typedef struct packed {
    logic pat_shift;
    logic text_shift;
  } pss_cell_ctrl_t;

endpackage

FILE: rtl/pss_cell.sv
// One compare cell: a pattern character, a text character and a match flag (pattern == text_in).
module pss_cell (
  input  logic                       clk,
  input  pss_pkg::pss_cell_ctrl_t    ctrl,
  input  logic [pss_pkg::CHAR_W-1:0] pat_in,
  input  logic [pss_pkg::CHAR_W-1:0] text_in,
  output logic [pss_pkg::CHAR_W-1:0] pat_q,
  output logic [pss_pkg::CHAR_W-1:0] text_q,
  output logic                       eq
);

  // text_in is the text character one position newer than this cell's slot
  assign eq = (text_in == pat_q);

  always_ff @(posedge clk) begin
    if (ctrl.pat_shift) begin
      pat_q <= pat_in;
    end
    if (ctrl.text_shift) begin
      text_q <= text_in;
    end
  end

endmodule

FILE: rtl/plain_substring_search_top.sv
// Top level of the streaming substring search.
// Finds the first occurrence of a loaded pattern of up to PATTERN_MAX code points in a
// streamed text region. Send a start item (tuser 0), then pattern characters (tuser 1),
// then text characters (tuser 2, tlast on the final one). Each cell of a row of
// PATTERN_MAX cells holds one pattern character (newest first) and one text character;
// the pattern row shifts by one on each append that fits, the text row on each stored text
// character; all cells compare in parallel, so one item is taken every clock cycle as long
// as the output side drains. A result appears in the output register the cycle after the
// item that causes it; at most one result is given per search. No clearing pass follows
// reset. start_offset may be written only while the block is idle.
module plain_substring_search_top #(
  parameter int PATTERN_MAX = 32,
  parameter int TEXT_MAX    = 65536
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [pss_pkg::CFG_W-1:0]    cfg_wr_data,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [pss_pkg::S_DATA_W-1:0] s_tdata,   // [20:0] char_value, [23:21] zero
  input  logic [pss_pkg::KIND_W-1:0]   s_tuser,   // [1:0] kind
  input  logic                         s_tlast,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [pss_pkg::M_DATA_W-1:0] m_tdata,   // [16:0] match_position, [22:17] match_length, [23] zero
  output logic [pss_pkg::STAT_W-1:0]   m_tuser    // [1:0] status
);

  `include "plain_substring_search_top_assert.svh"

  localparam int CNT_W = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W = $clog2(TEXT_MAX + 1);
  localparam int SUM_W = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;

  logic [pss_pkg::CFG_W-1:0]  start_offset;
  logic [CNT_W-1:0]           pattern_count;
  logic                       pattern_overflow;
  logic [IDX_W-1:0]           text_index;
  logic                       search_done;

  logic [pss_pkg::CHAR_W-1:0] pat_q  [PATTERN_MAX];
  logic [pss_pkg::CHAR_W-1:0] text_q [PATTERN_MAX];
  logic [PATTERN_MAX-1:0]     eq_vec;
  logic [PATTERN_MAX-1:0]     active_vec;

  pss_pkg::pss_kind_t         kind;
  logic [pss_pkg::CHAR_W-1:0] char_value;
  logic                       in_fire;
  logic                       is_start;
  logic                       is_append;
  logic                       is_text;
  logic                       pat_room;
  logic                       text_push;
  pss_pkg::pss_cell_ctrl_t    cell_ctrl;

  logic [SUM_W-1:0]           idx_plus1;
  logic [SUM_W-1:0]           cnt_ext;
  logic [SUM_W-1:0]           match_idx;
  logic                       window_ok;
  logic                       hit;
  logic                       text_full;

  logic                       res_valid;
  pss_pkg::pss_status_t       res_status;
  logic [pss_pkg::POS_W-1:0]  res_pos;
  logic [pss_pkg::LEN_W-1:0]  res_len;

  assign s_tready   = !m_tvalid || m_tready;
  assign in_fire    = s_tvalid && s_tready;
  assign kind       = pss_pkg::pss_kind_t'(s_tuser);
  assign char_value = s_tdata[pss_pkg::CHAR_W-1:0];

  assign is_start  = in_fire && (kind == pss_pkg::KIND_START);
  assign is_append = in_fire && (kind == pss_pkg::KIND_PATTERN);
  assign is_text   = in_fire && (kind == pss_pkg::KIND_TEXT) && !search_done;
  assign pat_room  = (pattern_count < CNT_W'(PATTERN_MAX));

  assign cell_ctrl.pat_shift  = is_append && pat_room;
  assign cell_ctrl.text_shift = text_push;

  genvar k;
  generate
    for (k = 0; k < PATTERN_MAX; k++) begin : g_cell
      logic [pss_pkg::CHAR_W-1:0] pat_in;
      logic [pss_pkg::CHAR_W-1:0] text_in;
      if (k == 0) begin : g_head
        assign pat_in  = char_value;
        assign text_in = char_value;
      end else begin : g_body
        assign pat_in  = pat_q[k-1];
        assign text_in = text_q[k-1];
      end
      pss_cell u_cell (
        .clk     (clk),
        .ctrl    (cell_ctrl),
        .pat_in  (pat_in),
        .text_in (text_in),
        .pat_q   (pat_q[k]),
        .text_q  (text_q[k]),
        .eq      (eq_vec[k])
      );
      assign active_vec[k] = (CNT_W'(k) < pattern_count);
    end
  endgenerate

  assign window_ok = &(eq_vec | ~active_vec);
  assign idx_plus1 = SUM_W'(text_index) + SUM_W'(1);
  assign cnt_ext   = SUM_W'(pattern_count);
  assign match_idx = idx_plus1 - cnt_ext;
  assign hit       = (idx_plus1 >= cnt_ext) && window_ok;
  assign text_full = (text_index >= IDX_W'(TEXT_MAX));

  always_comb begin
    res_valid  = 1'b0;
    res_status = pss_pkg::ST_FOUND;
    res_pos    = '0;
    res_len    = '0;
    text_push  = 1'b0;
    if (is_text) begin
      if (pattern_overflow) begin
        res_valid  = 1'b1;
        res_status = pss_pkg::ST_PAT_LONG;
      end else if (pattern_count == '0) begin
        res_valid  = 1'b1;
        res_pos    = pss_pkg::POS_W'(start_offset);
      end else if (text_full) begin
        res_valid  = 1'b1;
        res_status = pss_pkg::ST_TEXT_LONG;
      end else begin
        text_push = 1'b1;
        if (hit) begin
          res_valid = 1'b1;
          res_pos   = pss_pkg::POS_W'(start_offset) + pss_pkg::POS_W'(match_idx);
          res_len   = pss_pkg::LEN_W'(pattern_count);
        end else if (s_tlast) begin
          res_valid  = 1'b1;
          res_status = pss_pkg::ST_NOT_FOUND;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_offset     <= '0;
      pattern_count    <= '0;
      pattern_overflow <= 1'b0;
      text_index       <= '0;
      search_done      <= 1'b0;
      m_tvalid         <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        start_offset <= cfg_wr_data;
      end
      if (is_start) begin
        pattern_count    <= '0;
        pattern_overflow <= 1'b0;
        text_index       <= '0;
        search_done      <= 1'b0;
      end
      if (is_append) begin
        if (pat_room) begin
          pattern_count <= pattern_count + CNT_W'(1);
        end else begin
          pattern_overflow <= 1'b1;
        end
      end
      if (text_push) begin
        text_index <= text_index + IDX_W'(1);
      end
      if (res_valid) begin
        search_done <= 1'b1;
      end
      // reload the output register whenever its content is gone or taken
      if (s_tready) begin
        m_tvalid <= res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && res_valid) begin
      m_tuser <= res_status;
      m_tdata <= {1'b0, res_len, res_pos};
    end
  end

  `PSS_ASSERT_IMPL(a_cnt_range, clk, rst, 1'b1, pattern_count <= CNT_W'(PATTERN_MAX))
  `PSS_ASSERT_IMPL(a_ovf_full, clk, rst, pattern_overflow, pattern_count == CNT_W'(PATTERN_MAX))
  `PSS_ASSERT_NEXT(a_result_ends, clk, rst, res_valid && !is_start, search_done)
  `PSS_ASSERT_IMPL(a_done_quiet, clk, rst, search_done, !text_push && !res_valid)
  `PSS_ASSERT_IMPL(a_push_in_range, clk, rst, text_push, !text_full && (pattern_count != '0))

endmodule
